@@ rtl/lgfc_pkg.sv @@
// shared types, widths and constants of the light gate finger counter
package lgfc_pkg;

	localparam int MAX_CHANNELS = 3;
	localparam int CHANNELS_DEF = 3;

	localparam int CODE_W  = 10;
	localparam int COUNT_W = 8;
	localparam int UNIT_W  = 8;
	localparam int TOTAL_W = 15;
	localparam int EV_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DARK_BELOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_ABOVE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd3;

	localparam logic [CODE_W-1:0] DARK_BELOW_RST  = 10'd409;
	localparam logic [CODE_W-1:0] LIGHT_ABOVE_RST = 10'd410;
	localparam logic [UNIT_W-1:0] TICKS_PER_S_RST = 8'd16;
	localparam logic [UNIT_W-1:0] TIMEOUT_RST     = 8'd6;

	// event codes
	localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
	localparam logic [EV_W-1:0] EV_CLEAR  = 2'd1;
	localparam logic [EV_W-1:0] EV_REPORT = 2'd2;

	// request kinds
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [UNIT_W-1:0]  UNIT_MAX  = {UNIT_W{1'b1}};

	typedef struct packed {
		logic [CODE_W-1:0] dark_below;
		logic [CODE_W-1:0] light_above;
	} thresh_t;

	// what one lane shows for the current beat
	typedef struct packed {
		logic               edge_seen;
		logic               dark;
		logic [COUNT_W-1:0] count;
	} lane_st_t;

	typedef struct packed {
		logic                                  present;
		logic [MAX_CHANNELS-1:0][COUNT_W-1:0]  counts;
		logic [TOTAL_W-1:0]                    total;
		logic [EV_W-1:0]                       ev;
	} result_t;

endpackage

@@ rtl/lgfc_lane.sv @@
// one sensor channel: hysteresis compare, dark edge count, saturating counter
module lgfc_lane
	import lgfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_en,
	input  logic              clr,
	input  thresh_t           thr,
	input  logic [CODE_W-1:0] code,
	output lane_st_t          st
);

	logic               dark_q;
	logic [COUNT_W-1:0] count_q;
	logic               fall;
	logic               rise;
	logic               dark_nx;
	logic [COUNT_W-1:0] count_nx;

	always_comb begin
		fall = !dark_q && (code < thr.dark_below);
		rise = dark_q && (code > thr.light_above);
		count_nx = count_q;
		if (fall && count_q != COUNT_MAX) begin
			count_nx = count_q + COUNT_W'(1);
		end
		dark_nx = dark_q;
		if (fall) begin
			dark_nx = 1'b1;
		end else if (rise) begin
			dark_nx = 1'b0;
		end
	end

	// state as seen after this beat, before any timeout clear
	assign st.edge_seen = sample_en && (fall || rise);
	assign st.dark      = sample_en ? dark_nx : dark_q;
	assign st.count     = sample_en ? count_nx : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q  <= 1'b1;
			count_q <= '0;
		end else if (sample_en) begin
			if (clr) begin
				dark_q  <= 1'b1;
				count_q <= '0;
			end else begin
				dark_q  <= dark_nx;
				count_q <= count_nx;
			end
		end
	end

endmodule

@@ rtl/lgfc_merge.sv @@
// tick divider, elapsed time, timeout decision and merge of the lane results
module lgfc_merge
	import lgfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              req_type,
	input  logic [UNIT_W-1:0] ticks_per_s,
	input  logic [UNIT_W-1:0] timeout_units,
	input  lane_st_t          st [MAX_CHANNELS],
	output logic              clr,
	output result_t           res
);

	logic [UNIT_W-1:0] tick_div_q;
	logic [UNIT_W-1:0] elapsed_q;
	logic              is_tick;
	logic              is_smp;
	logic [UNIT_W:0]   div_p1;
	logic              wrap;
	logic              edge_any;
	logic              present;
	logic [UNIT_W-1:0] elapsed_nx;
	logic [TOTAL_W-1:0] total;

	always_comb begin
		is_tick = fire && (req_type == REQ_TICK);
		is_smp  = fire && (req_type == REQ_SAMPLE);
		div_p1  = {1'b0, tick_div_q} + (UNIT_W+1)'(1);
		wrap    = div_p1 >= {1'b0, ticks_per_s};
		edge_any = 1'b0;
		present  = 1'b0;
		for (int j = 0; j < MAX_CHANNELS; j++) begin
			edge_any = edge_any | st[j].edge_seen;
			present  = present | st[j].dark;
		end
		elapsed_nx = edge_any ? '0 : elapsed_q;
		clr = is_smp && (elapsed_nx > timeout_units);
		total = TOTAL_W'(st[2].count) * TOTAL_W'(100)
			+ TOTAL_W'(st[1].count) * TOTAL_W'(10)
			+ TOTAL_W'(st[0].count);

		res.present = present;
		res.ev      = EV_NONE;
		res.total   = '0;
		for (int j = 0; j < MAX_CHANNELS; j++) begin
			res.counts[j] = clr ? '0 : st[j].count;
		end
		if (clr) begin
			if (present) begin
				res.ev    = EV_REPORT;
				res.total = total;
			end else begin
				res.ev = EV_CLEAR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_div_q <= '0;
			elapsed_q  <= '0;
		end else if (is_tick) begin
			if (wrap) begin
				tick_div_q <= '0;
				if (elapsed_q != UNIT_MAX) begin
					elapsed_q <= elapsed_q + UNIT_W'(1);
				end
			end else begin
				tick_div_q <= div_p1[UNIT_W-1:0];
			end
		end else if (is_smp) begin
			elapsed_q <= clr ? '0 : elapsed_nx;
		end
	end

endmodule

@@ rtl/lgfc_skid.sv @@
// output register with a skid stage so the input side keeps flowing
module lgfc_skid
	import lgfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    in_fire;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_fire) begin
			skid_q <= in_data;
		end
	end

endmodule

@@ rtl/light_gate_finger_counter.sv @@
// Light gate finger counter: up to three sensor lanes (ones, tens, hundreds) compare each
// 10-bit sample against a dark and a light level and count light-to-dark edges in
// saturating 8-bit counters; timer ticks are divided into elapsed units, and on a sample
// beat past the timeout all counts clear, first reporting 100*hundreds+10*tens+ones if a
// finger is present. One beat is accepted every clock unless s_tready is low: lane counters,
// divider and elapsed count all update in the accept cycle, and the result is registered in
// the output register (or the skid register if it is busy); this two-entry stage lets input
// run on while a result waits; s_tready drops only when both entries hold results.
module light_gate_finger_counter
	import lgfc_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // sample_ones, sample_tens, sample_hundreds, zero pad
	input  logic                  s_tuser,  // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // reported_total, count_ones, count_tens,
	                                        // count_hundreds, finger_present
	output logic [EV_W-1:0]       m_tuser,  // event_res
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CODE_W-1:0] dark_below_q;
	logic [CODE_W-1:0] light_above_q;
	logic [UNIT_W-1:0] ticks_per_s_q;
	logic [UNIT_W-1:0] timeout_q;

	thresh_t  thr;
	lane_st_t st [MAX_CHANNELS];
	logic     fire;
	logic     smp_en;
	logic     clr;
	result_t  res;
	result_t  out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_below_q  <= DARK_BELOW_RST;
			light_above_q <= LIGHT_ABOVE_RST;
			ticks_per_s_q <= TICKS_PER_S_RST;
			timeout_q     <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DARK_BELOW:  dark_below_q  <= cfg_data;
				REG_LIGHT_ABOVE: light_above_q <= cfg_data;
				REG_TICKS_PER_S: ticks_per_s_q <= cfg_data[UNIT_W-1:0];
				REG_TIMEOUT:     timeout_q     <= cfg_data[UNIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign thr.dark_below  = dark_below_q;
	assign thr.light_above = light_above_q;

	assign fire   = s_tvalid && s_tready;
	assign smp_en = fire && (s_tuser == REQ_SAMPLE);

	for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_lane
		if (j < CHANNELS) begin : g_on
			lgfc_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.sample_en (smp_en),
				.clr       (clr),
				.thr       (thr),
				.code      (s_tdata[j*CODE_W +: CODE_W]),
				.st        (st[j])
			);
		end else begin : g_off
			// unused channel: never dark, never counts
			assign st[j] = '0;
		end
	end

	lgfc_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.req_type      (s_tuser),
		.ticks_per_s   (ticks_per_s_q),
		.timeout_units (timeout_q),
		.st            (st),
		.clr           (clr),
		.res           (res)
	);

	lgfc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {out_res.present, out_res.counts, out_res.total};
	assign m_tuser = out_res.ev;

endmodule

@@ tb/light_gate_finger_counter_tb.sv @@
// self-checking testbench for the light gate finger counter
`timescale 1ns / 1ps

module light_gate_finger_counter_tb;
	import lgfc_pkg::*;

	localparam int LANES        = CHANNELS_DEF;
	localparam int RESET_CYCLES = 12;
	localparam int HOLD_LEN     = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int BURST_CAP    = 300;

	typedef enum int {CODE_DARK, CODE_LIGHT, CODE_MID, CODE_ANY} code_kind_t;

	// tracks thresholds, timer and finger counts, and queues the result of every beat
	class finger_tally;
		logic [CODE_W-1:0]  dark_lvl;
		logic [CODE_W-1:0]  light_lvl;
		logic [UNIT_W-1:0]  tick_rate;
		logic [UNIT_W-1:0]  timeout_lim;
		logic [UNIT_W-1:0]  divider;
		logic [UNIT_W-1:0]  elapsed;
		logic               lane_dark [LANES];
		logic [COUNT_W-1:0] lane_count [LANES];
		result_t            results_due [$];
		int                 errors;

		function new();
			dark_lvl    = DARK_BELOW_RST;
			light_lvl   = LIGHT_ABOVE_RST;
			tick_rate   = TICKS_PER_S_RST;
			timeout_lim = TIMEOUT_RST;
			divider     = '0;
			errors      = 0;
			clear_counts();
		endfunction

		function void clear_counts();
			elapsed = '0;
			for (int j = 0; j < LANES; j++) begin
				lane_count[j] = '0;
				lane_dark[j]  = 1'b1;
			end
		endfunction

		function logic any_dark();
			logic p;
			p = 1'b0;
			for (int j = 0; j < LANES; j++)
				if (lane_dark[j])
					p = 1'b1;
			return p;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DARK_BELOW:  dark_lvl    = data;
				REG_LIGHT_ABOVE: light_lvl   = data;
				REG_TICKS_PER_S: tick_rate   = data[UNIT_W-1:0];
				REG_TIMEOUT:     timeout_lim = data[UNIT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(logic req, logic [LANES-1:0][CODE_W-1:0] codes);
			result_t r;
			logic    present;
			int      sum;
			r = '0;
			if (req == REQ_TICK) begin
				if (int'(divider) + 1 >= int'(tick_rate)) begin
					divider = '0;
					if (elapsed != UNIT_MAX)
						elapsed++;
				end else begin
					divider++;
				end
			end else begin
				for (int j = 0; j < LANES; j++) begin
					if (!lane_dark[j] && codes[j] < dark_lvl) begin
						if (lane_count[j] != COUNT_MAX)
							lane_count[j]++;
						elapsed      = '0;
						lane_dark[j] = 1'b1;
					end else if (lane_dark[j] && codes[j] > light_lvl) begin
						elapsed      = '0;
						lane_dark[j] = 1'b0;
					end
				end
			end
			// presence is taken before any timeout clear
			present = any_dark();
			if (req == REQ_SAMPLE && elapsed > timeout_lim) begin
				if (present) begin
					r.ev    = EV_REPORT;
					sum     = 100 * int'(lane_count[2]) + 10 * int'(lane_count[1])
						+ int'(lane_count[0]);
					r.total = sum[TOTAL_W-1:0];
				end else begin
					r.ev = EV_CLEAR;
				end
				clear_counts();
			end
			r.present = present;
			for (int j = 0; j < LANES; j++)
				r.counts[j] = lane_count[j];
			results_due.push_back(r);
		endfunction

		function void check_beat(logic [EV_W-1:0] ev, logic [M_TDATA_W-1:0] data);
			result_t            want;
			logic [COUNT_W-1:0] got_count;
			string              lane_name [3] = '{"count_ones", "count_tens", "count_hundreds"};
			if (results_due.size() == 0) begin
				$error("result beat with nothing pending: event_res %0d data %h", ev, data);
				errors++;
				return;
			end
			want = results_due.pop_front();
			if (ev !== want.ev) begin
				$error("event_res: expected %0d, got %0d", want.ev, ev);
				errors++;
			end
			if (data[TOTAL_W-1:0] !== want.total) begin
				$error("reported_total: expected %0d, got %0d", want.total, data[TOTAL_W-1:0]);
				errors++;
			end
			for (int j = 0; j < LANES; j++) begin
				got_count = data[TOTAL_W + j*COUNT_W +: COUNT_W];
				if (got_count !== want.counts[j]) begin
					$error("%s: expected %0d, got %0d", lane_name[j], want.counts[j], got_count);
					errors++;
				end
			end
			if (data[TOTAL_W + 3*COUNT_W] !== want.present) begin
				$error("finger_present: expected %0d, got %0d", want.present,
					data[TOTAL_W + 3*COUNT_W]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [EV_W-1:0]       m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	finger_tally sb;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          items_sent;
	logic        hold_req;
	int          hold_cnt;
	logic        hold_done;
	int          stall_cycles;

	light_gate_finger_counter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check every beat, then pick the next ready
	initial begin
		hold_cnt  = 0;
		hold_done = 1'b0;
	end
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tuser, m_tdata);
		if (hold_req && !hold_done) begin
			hold_cnt++;
			if (hold_cnt >= HOLD_LEN)
				hold_done = 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[light_gate_finger_counter] ERROR");
			$finish;
		end
	end

	function automatic logic [CODE_W-1:0] pick_code(code_kind_t kind);
		int lo;
		int hi;
		int roll;
		lo   = 0;
		hi   = 1023;
		roll = $urandom_range(0, 9);
		case (kind)
			CODE_DARK: if (sb.dark_lvl != 0) hi = int'(sb.dark_lvl) - 1;
			CODE_LIGHT: if (sb.light_lvl != 1023) lo = int'(sb.light_lvl) + 1;
			CODE_MID: begin
				lo = (sb.dark_lvl < sb.light_lvl) ? int'(sb.dark_lvl) : int'(sb.light_lvl);
				hi = (sb.dark_lvl < sb.light_lvl) ? int'(sb.light_lvl) : int'(sb.dark_lvl);
			end
			default: ;
		endcase
		if (roll == 0)
			return lo[CODE_W-1:0];
		if (roll == 1)
			return hi[CODE_W-1:0];
		return CODE_W'($urandom_range(lo, hi));
	endfunction

	// a code that keeps the lane in its present state
	function automatic logic [CODE_W-1:0] hold_code(int j);
		if (sb.lane_dark[j])
			return CODE_W'($urandom_range(0, sb.light_lvl));
		return CODE_W'($urandom_range(sb.dark_lvl, 1023));
	endfunction

	task automatic send_item(input logic req, input logic [CODE_W-1:0] c0,
		input logic [CODE_W-1:0] c1, input logic [CODE_W-1:0] c2);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {2'b00, c2, c1, c0};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(req, {c2, c1, c0});
		items_sent++;
	endtask

	task automatic send_tick();
		send_item(REQ_TICK, CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));
	endtask

	task automatic send_hold();
		send_item(REQ_SAMPLE, hold_code(0), hold_code(1), hold_code(2));
	endtask

	task automatic send_noise();
		send_item(1'($urandom_range(0, 1)), pick_code(CODE_ANY), pick_code(CODE_ANY),
			pick_code(CODE_ANY));
	endtask

	// fingers come and go, the hand mostly rests past the timeout, then a quiet sample or noise
	task automatic run_gesture();
		int                steps;
		int                need;
		int                burst;
		int                roll;
		logic [CODE_W-1:0] c [3];
		steps = $urandom_range(1, 10);
		repeat (steps) begin
			if ($urandom_range(0, 99) < 70) begin
				for (int j = 0; j < 3; j++) begin
					roll = $urandom_range(0, 9);
					c[j] = pick_code(roll < 4 ? CODE_DARK : (roll < 8 ? CODE_LIGHT : CODE_MID));
				end
				send_item(REQ_SAMPLE, c[0], c[1], c[2]);
			end else begin
				send_tick();
			end
		end
		need = (sb.timeout_lim >= sb.elapsed) ? int'(sb.timeout_lim) + 1 - int'(sb.elapsed) : 0;
		need = need * ((sb.tick_rate == 0) ? 1 : int'(sb.tick_rate));
		if (need > BURST_CAP)
			need = BURST_CAP;
		burst = ($urandom_range(0, 4) == 0) ? $urandom_range(0, need)
			: need + $urandom_range(0, 2);
		repeat (burst)
			send_tick();
		if ($urandom_range(0, 99) < 85)
			send_hold();
		else
			send_noise();
	endtask

	task automatic run_random(input int quota);
		int start;
		start = items_sent;
		while (items_sent - start < quota) begin
			if ($urandom_range(0, 3) != 0)
				run_gesture();
			else
				repeat ($urandom_range(1, 6)) send_noise();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] dark, input logic [CFG_DATA_W-1:0] light,
		input logic [CFG_DATA_W-1:0] rate, input logic [CFG_DATA_W-1:0] limit);
		write_reg(REG_DARK_BELOW, dark);
		write_reg(REG_LIGHT_ABOVE, light);
		write_reg(REG_TICKS_PER_S, rate);
		write_reg(REG_TIMEOUT, limit);
		cfg_valid <= 1'b0;
	endtask

	// wait until every pending result is checked, then a short tail
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.results_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	initial begin
		sb            = new();
		items_sent    = 0;
		stall_cycles  = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= REQ_TICK;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DARK_BELOW;
		cfg_data  <= '0;
		hold_req  <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: boundary codes right at the dark and light levels
		set_idling(29, 56);
		send_item(REQ_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
		send_item(REQ_SAMPLE, 10'd0, 10'd0, 10'd0);
		send_item(REQ_SAMPLE, 10'd410, 10'd410, 10'd410);
		send_item(REQ_SAMPLE, 10'd411, 10'd409, 10'd1023);
		send_item(REQ_SAMPLE, 10'd408, 10'd0, 10'd409);
		send_item(REQ_TICK, 10'h3ff, 10'h155, 10'h2aa);
		send_item(REQ_TICK, 10'h000, 10'h2aa, 10'h155);
		run_random(60);
		drain();

		// one tick per unit, zero timeout: report or clear, then a clear with no finger
		program_regs(10'd409, 10'd410, 10'd1, 10'd0);
		send_tick();
		send_hold();
		send_item(REQ_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
		send_tick();
		send_hold();
		hold_req <= 1'b1;
		run_random(80);
		drain();

		set_idling(56, 29);
		program_regs(10'd512, 10'd600, 10'd2, 10'd3);
		run_random(100);
		drain();

		// timeout that never passes: drive counts and elapsed units into saturation
		program_regs(10'd1023, 10'd0, 10'h100, 10'h0ff);
		repeat (260) begin
			send_item(REQ_SAMPLE, pick_code(CODE_LIGHT), pick_code(CODE_LIGHT),
				pick_code(CODE_LIGHT));
			send_item(REQ_SAMPLE, pick_code(CODE_DARK), pick_code(CODE_DARK),
				pick_code(CODE_DARK));
		end
		repeat (260) send_tick();
		drain();

		// saturated counts carry over and get reported at the largest total
		set_idling(0, 0);
		program_regs(10'd300, 10'd700, 10'd255, 10'd0);
		send_hold();
		run_random(20);
		drain();

		// no code can go dark or light
		program_regs(10'd0, 10'd1023, 10'd3, 10'd2);
		run_random(60);
		drain();

		program_regs(10'd409, 10'd410, 10'h310, 10'h306);
		run_random(40);
		drain();

		if (sb.errors == 0)
			$display("[light_gate_finger_counter] OK");
		else
			$display("[light_gate_finger_counter] ERROR");
		$finish;
	end

endmodule
